// ----- rtl/core/cfds_pkg.sv -----
`default_nettype none

package cfds_pkg;

  // Component format: signed, FRAC fraction bits
  localparam int CW   = 16;
  localparam int FRAC = CW - 2;

  localparam int PW   = 2 * CW;      // one component product
  localparam int DW   = 2 * CW + 1;  // sum of two products, signed
  localparam int MW   = 2 * CW;      // dot product magnitude
  localparam int N2W  = 2 * CW;      // squared length
  localparam int SW   = CW;          // integer square root
  localparam int QW   = FRAC + 1;    // normalized magnitude, at most 2^FRAC
  localparam int NUMW = CW + FRAC;   // divide numerator

  localparam int MODE_W = 2;

  localparam logic signed [CW-1:0] COMP_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] COMP_MIN = {1'b1, {(CW - 1){1'b0}}};

  // Magnitudes below this count as no alignment with the previous direction
  localparam logic [MW-1:0] DOT_THR = MW'(((64'd1 << (2 * FRAC)) / 64'd1000) + 64'd1);

  typedef logic signed [CW-1:0] comp_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CROSS       = 2'd0,
    MODE_NORM_FIRST  = 2'd1,
    MODE_NORM_SECOND = 2'd2,
    MODE_ZERO        = 2'd3
  } mode_t;

  typedef struct packed {
    comp_t first_x;
    comp_t first_y;
    comp_t second_x;
    comp_t second_y;
    comp_t prev_x;
    comp_t prev_y;
  } in_beat_t;

  typedef struct packed {
    mode_t           mode;
    logic            sign_x;
    logic            sign_y;
    logic [CW-1:0]   mag_x;
    logic [CW-1:0]   mag_y;
    logic [N2W-1:0]  n2;
    comp_t           cross_x;
    comp_t           cross_y;
  } front_beat_t;

  typedef struct packed {
    mode_t          mode;
    logic           sign_x;
    logic           sign_y;
    logic           zero;
    logic [QW-1:0]  q_x;
    logic [QW-1:0]  q_y;
    comp_t          cross_x;
    comp_t          cross_y;
  } norm_beat_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfds_front.sv -----
`default_nettype none

module cfds_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cfds_pkg::mode_t       mode,
  input  cfds_pkg::in_beat_t    in_beat,
  output logic                  out_valid,
  output cfds_pkg::front_beat_t out_beat
);

  localparam int CW  = cfds_pkg::CW;
  localparam int PW  = cfds_pkg::PW;
  localparam int DW  = cfds_pkg::DW;
  localparam int MW  = cfds_pkg::MW;
  localparam int N2W = cfds_pkg::N2W;

  typedef struct packed {
    cfds_pkg::mode_t mode;
    cfds_pkg::comp_t ax;
    cfds_pkg::comp_t ay;
    cfds_pkg::comp_t bx;
    cfds_pkg::comp_t by;
    logic            sign_x;
    logic            sign_y;
    logic [CW-1:0]   mag_x;
    logic [CW-1:0]   mag_y;
  } carry_t;

  function automatic cfds_pkg::comp_t negate_sat(input cfds_pkg::comp_t v);
    if (v == cfds_pkg::COMP_MIN) begin
      return cfds_pkg::COMP_MAX;
    end
    return -v;
  endfunction

  logic                 skid_valid;
  cfds_pkg::in_beat_t   skid;
  logic [4:0]           v;

  cfds_pkg::in_beat_t   s0;
  cfds_pkg::mode_t      s0_mode;

  logic signed [PW-1:0] s1_pax, s1_pay, s1_pbx, s1_pby, s1_sqx, s1_sqy;
  carry_t               s1_c;

  logic signed [DW-1:0] s2_dot1, s2_dot2;
  logic [N2W-1:0]       s2_n2;
  carry_t               s2_c;

  logic [MW-1:0]        s3_m1, s3_m2;
  logic                 s3_neg1, s3_neg2;
  logic [N2W-1:0]       s3_n2;
  carry_t               s3_c;

  cfds_pkg::comp_t      vx, vy;
  carry_t               c1;
  logic signed [DW-1:0] dot1_neg, dot2_neg;
  logic                 below, first_wins;

  assign in_stall  = skid_valid;
  assign out_valid = v[4];

  // Hold an accepted beat here while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (adv) begin
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && !skid_valid) begin
      skid <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[3:0], skid_valid || in_valid};
    end
  end

  always_comb begin
    vx = (s0_mode == cfds_pkg::MODE_NORM_SECOND) ? s0.second_x : s0.first_x;
    vy = (s0_mode == cfds_pkg::MODE_NORM_SECOND) ? s0.second_y : s0.first_y;
    c1.mode   = s0_mode;
    c1.ax     = s0.first_x;
    c1.ay     = s0.first_y;
    c1.bx     = s0.second_x;
    c1.by     = s0.second_y;
    c1.sign_x = vx[CW-1];
    c1.sign_y = vy[CW-1];
    c1.mag_x  = vx[CW-1] ? (~vx + 1'b1) : vx;
    c1.mag_y  = vy[CW-1] ? (~vy + 1'b1) : vy;

    dot1_neg = -s2_dot1;
    dot2_neg = -s2_dot2;

    below      = (s3_m1 < cfds_pkg::DOT_THR) && (s3_m2 < cfds_pkg::DOT_THR);
    first_wins = s3_m1 >= s3_m2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0      <= skid_valid ? skid : in_beat;
      s0_mode <= mode;

      s1_pax <= $signed(s0.first_x) * $signed(s0.prev_x);
      s1_pay <= $signed(s0.first_y) * $signed(s0.prev_y);
      s1_pbx <= $signed(s0.second_x) * $signed(s0.prev_x);
      s1_pby <= $signed(s0.second_y) * $signed(s0.prev_y);
      s1_sqx <= vx * vx;
      s1_sqy <= vy * vy;
      s1_c   <= c1;

      s2_dot1 <= $signed({s1_pax[PW-1], s1_pax}) + $signed({s1_pay[PW-1], s1_pay});
      s2_dot2 <= $signed({s1_pbx[PW-1], s1_pbx}) + $signed({s1_pby[PW-1], s1_pby});
      s2_n2   <= $unsigned(s1_sqx) + $unsigned(s1_sqy);
      s2_c    <= s1_c;

      s3_m1   <= s2_dot1[DW-1] ? dot1_neg[MW-1:0] : s2_dot1[MW-1:0];
      s3_m2   <= s2_dot2[DW-1] ? dot2_neg[MW-1:0] : s2_dot2[MW-1:0];
      s3_neg1 <= s2_dot1[DW-1];
      s3_neg2 <= s2_dot2[DW-1];
      s3_n2   <= s2_n2;
      s3_c    <= s2_c;

      out_beat.mode   <= s3_c.mode;
      out_beat.sign_x <= s3_c.sign_x;
      out_beat.sign_y <= s3_c.sign_y;
      out_beat.mag_x  <= s3_c.mag_x;
      out_beat.mag_y  <= s3_c.mag_y;
      out_beat.n2     <= s3_n2;
      if (below) begin
        out_beat.cross_x <= '0;
        out_beat.cross_y <= '0;
      end else if (first_wins) begin
        out_beat.cross_x <= s3_neg1 ? negate_sat(s3_c.ax) : s3_c.ax;
        out_beat.cross_y <= s3_neg1 ? negate_sat(s3_c.ay) : s3_c.ay;
      end else begin
        out_beat.cross_x <= s3_neg2 ? negate_sat(s3_c.bx) : s3_c.bx;
        out_beat.cross_y <= s3_neg2 ? negate_sat(s3_c.by) : s3_c.by;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cfds_norm.sv -----
`default_nettype none

module cfds_norm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  cfds_pkg::front_beat_t in_beat,
  output logic                  out_valid,
  output cfds_pkg::norm_beat_t  out_beat
);

  localparam int CW   = cfds_pkg::CW;
  localparam int FRAC = cfds_pkg::FRAC;
  localparam int N2W  = cfds_pkg::N2W;
  localparam int SW   = cfds_pkg::SW;
  localparam int QW   = cfds_pkg::QW;
  localparam int NUMW = cfds_pkg::NUMW;
  localparam int SQ   = SW;            // one root bit per stage
  localparam int NS   = SQ + 1 + QW;   // root, numerator setup, one quotient bit per stage

  typedef struct packed {
    cfds_pkg::mode_t  mode;
    logic             sign_x;
    logic             sign_y;
    logic             zero;
    logic [CW-1:0]    mag_x;
    logic [CW-1:0]    mag_y;
    cfds_pkg::comp_t  cross_x;
    cfds_pkg::comp_t  cross_y;
    logic [N2W-1:0]   sq_rem;
    logic [N2W-1:0]   root;
    logic [SW-1:0]    s;
    logic [NUMW-1:0]  r_x;
    logic [NUMW-1:0]  r_y;
    logic [QW-1:0]    q_x;
    logic [QW-1:0]    q_y;
  } stage_t;

  stage_t          st  [NS];
  stage_t          nxt [NS];
  logic [NS-1:0]   v;

  always_comb begin
    stage_t          cur;
    logic [N2W-1:0]  bit_w;
    logic [N2W-1:0]  sq_try;
    logic [NUMW-1:0] trial;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        cur         = '0;
        cur.mode    = in_beat.mode;
        cur.sign_x  = in_beat.sign_x;
        cur.sign_y  = in_beat.sign_y;
        cur.zero    = (in_beat.n2 == '0);
        cur.mag_x   = in_beat.mag_x;
        cur.mag_y   = in_beat.mag_y;
        cur.cross_x = in_beat.cross_x;
        cur.cross_y = in_beat.cross_y;
        cur.sq_rem  = in_beat.n2;
      end else begin
        cur = st[k-1];
      end
      bit_w  = '0;
      sq_try = '0;
      trial  = '0;
      if (k < SQ) begin
        // one digit of the restoring square root
        bit_w  = N2W'(1) << (2 * (SQ - 1 - k));
        sq_try = cur.root + bit_w;
        if (cur.sq_rem >= sq_try) begin
          cur.sq_rem = cur.sq_rem - sq_try;
          cur.root   = (cur.root >> 1) + bit_w;
        end else begin
          cur.root = cur.root >> 1;
        end
      end else if (k == SQ) begin
        // numerator is |c| scaled up, plus half the divisor for rounding
        cur.s   = cur.root[SW-1:0];
        cur.r_x = {cur.mag_x, {FRAC{1'b0}}} + NUMW'(cur.root[SW-1:1]);
        cur.r_y = {cur.mag_y, {FRAC{1'b0}}} + NUMW'(cur.root[SW-1:1]);
        cur.q_x = '0;
        cur.q_y = '0;
      end else begin
        trial = NUMW'(cur.s) << (NS - 1 - k);
        if (cur.r_x >= trial) begin
          cur.r_x = cur.r_x - trial;
          cur.q_x = cur.q_x | (QW'(1) << (NS - 1 - k));
        end
        if (cur.r_y >= trial) begin
          cur.r_y = cur.r_y - trial;
          cur.q_y = cur.q_y | (QW'(1) << (NS - 1 - k));
        end
      end
      nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign out_valid        = v[NS-1];
  assign out_beat.mode    = st[NS-1].mode;
  assign out_beat.sign_x  = st[NS-1].sign_x;
  assign out_beat.sign_y  = st[NS-1].sign_y;
  assign out_beat.zero    = st[NS-1].zero;
  assign out_beat.q_x     = st[NS-1].q_x;
  assign out_beat.q_y     = st[NS-1].q_y;
  assign out_beat.cross_x = st[NS-1].cross_x;
  assign out_beat.cross_y = st[NS-1].cross_y;

endmodule

`default_nettype wire

// ----- rtl/core/cross_field_direction_select.sv -----
`default_nettype none

// Cross-field direction select.
// Input channel (in_valid / in_stall) carries two field vectors and the
// previous direction, all signed Q1.14; a beat is taken when in_valid is high
// and in_stall is low. The output channel (out_valid / out_stall) returns one
// direction beat per input beat, in order.
// select_mode is written over cfg_valid / cfg_ready (ready always high); write
// it only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. The
// accepting edge loads the input register; out_valid follows after four front
// stages (products, sums, magnitudes, select), sixteen square-root stages, one
// numerator stage, fifteen divide stages and the output register.
// Reset clears select_mode to cross-field choice and empties every stage.
// While the receiver stalls a waiting result, the whole pipeline holds; one
// more input beat is still taken into a skid register, after which in_stall
// stays high until the output moves again.

module cross_field_direction_select (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cfds_pkg::MODE_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [cfds_pkg::CW-1:0]       first_x,
  input  logic signed [cfds_pkg::CW-1:0]       first_y,
  input  logic signed [cfds_pkg::CW-1:0]       second_x,
  input  logic signed [cfds_pkg::CW-1:0]       second_y,
  input  logic signed [cfds_pkg::CW-1:0]       prev_x,
  input  logic signed [cfds_pkg::CW-1:0]       prev_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cfds_pkg::CW-1:0]       dir_x,
  output logic signed [cfds_pkg::CW-1:0]       dir_y
);

  localparam int CW   = cfds_pkg::CW;
  localparam int FRAC = cfds_pkg::FRAC;
  localparam int QW   = cfds_pkg::QW;
  localparam logic [QW-1:0] Q_UNIT = {1'b1, {FRAC{1'b0}}};

  cfds_pkg::mode_t       select_mode;
  cfds_pkg::in_beat_t    in_beat;
  logic                  adv;
  logic                  front_valid;
  cfds_pkg::front_beat_t front_beat;
  logic                  norm_valid;
  cfds_pkg::norm_beat_t  norm_beat;
  cfds_pkg::comp_t       dir_x_next, dir_y_next;
  logic [CW-1:0]         mag_x, mag_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode <= cfds_pkg::MODE_CROSS;
    end else if (cfg_valid && cfg_ready) begin
      select_mode <= cfds_pkg::mode_t'(cfg_data);
    end
  end

  // Advance every stage together unless a finished result is stalled
  assign adv = !out_valid || !out_stall;

  assign in_beat.first_x  = first_x;
  assign in_beat.first_y  = first_y;
  assign in_beat.second_x = second_x;
  assign in_beat.second_y = second_y;
  assign in_beat.prev_x   = prev_x;
  assign in_beat.prev_y   = prev_y;

  cfds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (select_mode),
    .in_beat   (in_beat),
    .out_valid (front_valid),
    .out_beat  (front_beat)
  );

  cfds_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .in_beat   (front_beat),
    .out_valid (norm_valid),
    .out_beat  (norm_beat)
  );

  always_comb begin
    mag_x = {{(CW - QW){1'b0}}, norm_beat.q_x};
    mag_y = {{(CW - QW){1'b0}}, norm_beat.q_y};
    case (norm_beat.mode)
      cfds_pkg::MODE_CROSS: begin
        dir_x_next = norm_beat.cross_x;
        dir_y_next = norm_beat.cross_y;
      end
      cfds_pkg::MODE_NORM_FIRST, cfds_pkg::MODE_NORM_SECOND: begin
        if (norm_beat.zero) begin
          dir_x_next = '0;
          dir_y_next = '0;
        end else begin
          dir_x_next = norm_beat.sign_x ? -$signed(mag_x) : $signed(mag_x);
          dir_y_next = norm_beat.sign_y ? -$signed(mag_y) : $signed(mag_y);
        end
      end
      default: begin
        dir_x_next = '0;
        dir_y_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= norm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_x <= dir_x_next;
      dir_y <= dir_y_next;
    end
  end

  // The skid register only fills while the output is stalled
  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled output");

  // Normalized magnitudes never exceed one
  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    (norm_valid && !norm_beat.zero &&
     (norm_beat.mode == cfds_pkg::MODE_NORM_FIRST ||
      norm_beat.mode == cfds_pkg::MODE_NORM_SECOND))
    |-> (norm_beat.q_x <= Q_UNIT && norm_beat.q_y <= Q_UNIT))
    else $error("normalized component above unit length");

  // A nonzero vector never normalizes to zero
  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    (norm_valid && !norm_beat.zero &&
     (norm_beat.mode == cfds_pkg::MODE_NORM_FIRST ||
      norm_beat.mode == cfds_pkg::MODE_NORM_SECOND))
    |-> (norm_beat.q_x != '0 || norm_beat.q_y != '0))
    else $error("nonzero vector normalized to zero");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    cfds_pkg::comp_t x;
    cfds_pkg::comp_t y;
  } dir_t;

  typedef struct packed {
    cfds_pkg::mode_t mode;
    cfds_pkg::comp_t ax;
    cfds_pkg::comp_t ay;
    cfds_pkg::comp_t bx;
    cfds_pkg::comp_t by;
    cfds_pkg::comp_t px;
    cfds_pkg::comp_t py;
    logic            typed;
    dir_t            want;
  } beat_t;

  localparam longint DOT_LIMIT = ((longint'(1) << (2 * cfds_pkg::FRAC)) / 1000) + 1;
  localparam int HOLD_CYCLES = 160;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_BEATS = 78;
  localparam int QUIET_PHASE = 5;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  [cfds_pkg::MODE_W-1:0] cfg_data = '0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  cfds_pkg::comp_t first_x = '0;
  cfds_pkg::comp_t first_y = '0;
  cfds_pkg::comp_t second_x = '0;
  cfds_pkg::comp_t second_y = '0;
  cfds_pkg::comp_t prev_x = '0;
  cfds_pkg::comp_t prev_y = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  cfds_pkg::comp_t dir_x;
  cfds_pkg::comp_t dir_y;

  // side info for the beat on the input port, read when it is taken
  logic  beat_typed = 1'b0;
  dir_t  beat_want = '0;

  dir_t  pending_dirs[$];
  beat_t directed_rows[$];
  cfds_pkg::mode_t active_mode = cfds_pkg::MODE_CROSS;
  cfds_pkg::mode_t drive_mode = cfds_pkg::MODE_CROSS;
  cfds_pkg::mode_t row_mode = cfds_pkg::MODE_CROSS;
  int    mismatches = 0;
  int    results_checked = 0;
  int    beats_sent = 0;
  int    mode_writes = 0;
  int    burst_left = 0;
  int    hold_at = 1 << 30;
  bit    quiet = 1'b0;

  cross_field_direction_select uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .first_x   (first_x),
    .first_y   (first_y),
    .second_x  (second_x),
    .second_y  (second_y),
    .prev_x    (prev_x),
    .prev_y    (prev_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dir_x     (dir_x),
    .dir_y     (dir_y)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic cfds_pkg::comp_t neg_sat(input cfds_pkg::comp_t v);
    return (v == cfds_pkg::COMP_MIN) ? cfds_pkg::COMP_MAX : cfds_pkg::comp_t'(-v);
  endfunction

  function automatic cfds_pkg::comp_t unit_comp(input cfds_pkg::comp_t c, input longint root);
    longint mag;
    longint q;
    mag = (c < 0) ? -longint'(c) : longint'(c);
    q = ((mag << cfds_pkg::FRAC) + (root >>> 1)) / root;
    if (q > longint'(cfds_pkg::COMP_MAX)) q = longint'(cfds_pkg::COMP_MAX);
    return (c < 0) ? cfds_pkg::comp_t'(-q) : cfds_pkg::comp_t'(q);
  endfunction

  function automatic dir_t unit_vec(input cfds_pkg::comp_t x, input cfds_pkg::comp_t y);
    longint len2;
    longint root;
    longint trial;
    dir_t   r;
    len2 = longint'(x) * longint'(x) + longint'(y) * longint'(y);
    r = '0;
    if (len2 != 0) begin
      root = 0;
      for (int b = 16; b >= 0; b--) begin
        trial = root + (longint'(1) << b);
        if (trial * trial <= len2) root = trial;
      end
      r.x = unit_comp(x, root);
      r.y = unit_comp(y, root);
    end
    return r;
  endfunction

  function automatic dir_t predict_dir(input cfds_pkg::mode_t m,
                                       input cfds_pkg::comp_t ax, input cfds_pkg::comp_t ay,
                                       input cfds_pkg::comp_t bx, input cfds_pkg::comp_t by,
                                       input cfds_pkg::comp_t px, input cfds_pkg::comp_t py);
    longint d1;
    longint d2;
    longint m1;
    longint m2;
    dir_t   r;
    r = '0;
    case (m)
      cfds_pkg::MODE_CROSS: begin
        d1 = longint'(ax) * longint'(px) + longint'(ay) * longint'(py);
        d2 = longint'(bx) * longint'(px) + longint'(by) * longint'(py);
        m1 = (d1 < 0) ? -d1 : d1;
        m2 = (d2 < 0) ? -d2 : d2;
        if (m1 < DOT_LIMIT && m2 < DOT_LIMIT) begin
          r = '0;
        end else if (m1 >= m2) begin
          r.x = (d1 < 0) ? neg_sat(ax) : ax;
          r.y = (d1 < 0) ? neg_sat(ay) : ay;
        end else begin
          r.x = (d2 < 0) ? neg_sat(bx) : bx;
          r.y = (d2 < 0) ? neg_sat(by) : by;
        end
      end
      cfds_pkg::MODE_NORM_FIRST:  r = unit_vec(ax, ay);
      cfds_pkg::MODE_NORM_SECOND: r = unit_vec(bx, by);
      default:                    r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch @%0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // input and output side, one process so the order of push and pop is fixed
  always @(posedge clk) begin
    dir_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) active_mode = cfds_pkg::mode_t'(cfg_data);
      if (in_valid && !in_stall) begin
        if (beat_typed)
          want = beat_want;
        else
          want = predict_dir(active_mode, first_x, first_y, second_x, second_y,
                             prev_x, prev_y);
        pending_dirs = {pending_dirs, want};
      end
      if (out_valid && !out_stall) begin
        if (pending_dirs.size() == 0) begin
          report_mismatch("result with nothing pending, dir_x", dir_x, 0);
        end else begin
          want = pending_dirs.pop_front();
          results_checked++;
          if (dir_x !== want.x) report_mismatch("dir_x", dir_x, want.x);
          if (dir_y !== want.y) report_mismatch("dir_y", dir_y, want.y);
        end
      end
    end
  end

  // receiver: alternating runs, plus one long hold-off to fill the pipe
  always @(negedge clk) begin
    static int  run_left = 0;
    static int  hold_left = 0;
    static bit  hold_done = 1'b0;
    static bit  stalling = 1'b0;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!hold_done && beats_sent >= hold_at) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        stalling = !stalling;
        run_left = stalling ? $urandom_range(1, 5) : $urandom_range(1, 12);
      end
      run_left--;
      out_stall <= stalling;
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_beat(input beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = quiet ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    first_x    <= b.ax;
    first_y    <= b.ay;
    second_x   <= b.bx;
    second_y   <= b.by;
    prev_x     <= b.px;
    prev_y     <= b.py;
    beat_typed <= b.typed;
    beat_want  <= b.want;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_dirs.size() != 0) @(negedge clk);
  endtask

  task automatic write_mode(input cfds_pkg::mode_t m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    drive_mode = m;
    mode_writes++;
  endtask

  // one table row in the mode held by row_mode
  task automatic add_row(input int ax, input int ay, input int bx,
                         input int by, input int px, input int py,
                         input bit typed, input int wx, input int wy);
    beat_t b;
    b.mode = row_mode;
    b.ax = cfds_pkg::comp_t'(ax);
    b.ay = cfds_pkg::comp_t'(ay);
    b.bx = cfds_pkg::comp_t'(bx);
    b.by = cfds_pkg::comp_t'(by);
    b.px = cfds_pkg::comp_t'(px);
    b.py = cfds_pkg::comp_t'(py);
    b.typed = typed;
    b.want.x = cfds_pkg::comp_t'(wx);
    b.want.y = cfds_pkg::comp_t'(wy);
    directed_rows = {directed_rows, b};
  endtask

  function automatic cfds_pkg::comp_t pick_corner();
    case ($urandom_range(0, 9))
      0: return cfds_pkg::COMP_MIN;
      1: return cfds_pkg::COMP_MAX;
      2: return cfds_pkg::comp_t'(-32767);
      3: return cfds_pkg::comp_t'(-1);
      4: return cfds_pkg::comp_t'(1);
      5: return cfds_pkg::comp_t'(16384);
      6: return cfds_pkg::comp_t'(-16384);
      7: return cfds_pkg::comp_t'(2);
      default: return cfds_pkg::comp_t'(0);
    endcase
  endfunction

  function automatic cfds_pkg::comp_t pick_span(input int lim);
    return cfds_pkg::comp_t'($signed($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int    kind;
    b = '0;
    b.mode = drive_mode;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      b.ax = cfds_pkg::comp_t'($urandom); b.ay = cfds_pkg::comp_t'($urandom);
      b.bx = cfds_pkg::comp_t'($urandom); b.by = cfds_pkg::comp_t'($urandom);
      b.px = cfds_pkg::comp_t'($urandom); b.py = cfds_pkg::comp_t'($urandom);
    end else if (kind < 50) begin
      b.ax = pick_span(16384); b.ay = pick_span(16384);
      b.bx = pick_span(16384); b.by = pick_span(16384);
      b.px = pick_span(16384); b.py = pick_span(16384);
    end else if (kind < 70) begin
      // dot products around the near-zero threshold
      b.ax = pick_span(600); b.ay = pick_span(600);
      b.bx = pick_span(600); b.by = pick_span(600);
      b.px = pick_span(600); b.py = pick_span(600);
    end else if (kind < 85) begin
      // equal magnitudes, first must win
      b.ax = pick_span(16384); b.ay = pick_span(16384);
      b.px = pick_span(32767); b.py = pick_span(32767);
      case ($urandom_range(0, 2))
        0: begin b.bx = b.ax; b.by = b.ay; end
        1: begin b.bx = -b.ax; b.by = -b.ay; end
        default: begin b.bx = b.ay; b.by = b.ax; b.py = b.px; end
      endcase
    end else begin
      b.ax = pick_corner(); b.ay = pick_corner();
      b.bx = pick_corner(); b.by = pick_corner();
      b.px = pick_corner(); b.py = pick_corner();
    end
    return b;
  endfunction

  initial begin
    cfds_pkg::mode_t phase_modes[RAND_PHASES];
    phase_modes = '{cfds_pkg::MODE_CROSS, cfds_pkg::MODE_NORM_FIRST, cfds_pkg::MODE_CROSS,
                    cfds_pkg::MODE_NORM_SECOND, cfds_pkg::MODE_ZERO, cfds_pkg::MODE_CROSS,
                    cfds_pkg::MODE_NORM_SECOND, cfds_pkg::MODE_NORM_FIRST,
                    cfds_pkg::MODE_CROSS};

    row_mode = cfds_pkg::MODE_CROSS;
    //         ax      ay      bx      by      px      py  typed  wx     wy
    add_row(     0,      0,      0,      0,      0,      0,  1,     0,     0);
    add_row( 16384,      0,      0,  16384,  16384,      0,  1, 16384,     0);
    add_row( 16384,      0,      0,  16384, -16384,      0,  1,-16384,     0);
    add_row(   100,    200,    200,    100,  16384,  16384,  1,   100,   200);
    add_row(-32768, -32768,      0,      0,  16384,  16384,  1, 32767, 32767);
    add_row(    16,   6291,      0,      0,  16384,      1,  1,     0,     0);
    add_row(    16,   6292,      0,      0,  16384,      1,  1,    16,  6292);
    add_row( 32767,  32767, -32768, -32768, -32768, -32768,  1,-32768,-32768);
    add_row( 32767,  32767, -32768, -32768,  32767,  32767,  1, 32767, 32767);
    add_row(    -5,    300,  -1200,     77,   -410,    903,  0,     0,     0);
    add_row( 12000,  -9000,   9000,  12000,   3000,   4000,  0,     0,     0);
    row_mode = cfds_pkg::MODE_NORM_FIRST;
    add_row(     0,      0,   5000,   5000,   1000,   1000,  1,     0,     0);
    add_row( 16384,      0,      0,      0,      0,      0,  1, 16384,     0);
    add_row(    -1,      0,   7777,   -123,      0,      0,  1,-16384,     0);
    add_row(-32768, -32768,      0,      0,      0,      0,  0,     0,     0);
    add_row(     3,      4,      0,      0,      0,      0,  0,     0,     0);
    add_row( 32767, -32768,      1,      1,  32767,  32767,  0,     0,     0);
    row_mode = cfds_pkg::MODE_NORM_SECOND;
    add_row(  1234,  -4321,      0,      0,      5,      5,  1,     0,     0);
    add_row(     0,      0,      0, -32768,      0,      0,  1,     0,-16384);
    add_row(     0,      0,  32767, -32768,      0,      0,  0,     0,     0);
    add_row(     0,      0,      1,      1,      0,      0,  0,     0,     0);
    row_mode = cfds_pkg::MODE_ZERO;
    add_row( 32767,  32767,  32767,  32767,  32767,  32767,  1,     0,     0);
    add_row(-32768,   1234,   -999,  16384, -16384,      7,  1,     0,     0);

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != drive_mode) begin
        drain_pipe();
        write_mode(directed_rows[i].mode);
      end
      send_beat(directed_rows[i]);
    end

    hold_at = beats_sent + 2 * PHASE_BEATS + 20;
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_pipe();
      write_mode(phase_modes[p]);
      quiet = (p == QUIET_PHASE);
      repeat (PHASE_BEATS) send_beat(random_beat());
    end
    quiet = 1'b0;

    drain_pipe();
    repeat (40) @(posedge clk);
    if (pending_dirs.size() != 0)
      report_mismatch("results missing at end, count", pending_dirs.size(), 0);

    $display("sent %0d beats over %0d mode writes (all four modes, long output hold-off)",
             beats_sent, mode_writes);
    $display("checked %0d direction results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
